@@ hdl/lpbc_pkg.sv @@
// Package: shared types and constants for the LED pulse and blink controller.
`timescale 1ns / 1ps
package lpbc_pkg;

  typedef enum logic [2:0] {
    ACT_TICK        = 3'd0,
    ACT_GREEN_SET   = 3'd1,
    ACT_RED_SET     = 3'd2,
    ACT_RED_BLINK   = 3'd3,
    ACT_GREEN_PULSE = 3'd4,
    ACT_RED_PULSE   = 3'd5
  } action_t;

  localparam int unsigned HALF_DIV = 2;

  localparam logic [15:0] PULSE_CNT_MAX = 16'hFFFF;
  localparam logic [14:0] BLINK_CNT_MAX = 15'h7FFF;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] value;
  } in_word_t;

  typedef struct packed {
    logic green_on;
    logic red_on;
  } out_word_t;

endpackage

@@ hdl/lpbc_engine.sv @@
// LED state registers and the per-word update of pulses, blink and drives.
`timescale 1ns / 1ps
module lpbc_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                upd_en,
  input  lpbc_pkg::in_word_t  upd_word,
  output lpbc_pkg::out_word_t led_nxt
);

  logic        green_lit_r, green_lit_nxt;
  logic        red_lit_r, red_lit_nxt;
  logic        gp_run_r, gp_run_nxt;
  logic [15:0] gp_elapsed_r, gp_elapsed_nxt;
  logic [15:0] gp_length_r, gp_length_nxt;
  logic        rp_run_r, rp_run_nxt;
  logic [15:0] rp_elapsed_r, rp_elapsed_nxt;
  logic [15:0] rp_length_r, rp_length_nxt;
  logic        blink_run_r, blink_run_nxt;
  logic [14:0] blink_half_r, blink_half_nxt;
  logic [14:0] blink_elapsed_r, blink_elapsed_nxt;

  logic [15:0] gp_inc;
  logic [15:0] rp_inc;
  logic [14:0] blink_inc;
  logic [14:0] half_full;

  // saturating increments used on a tick
  assign gp_inc    = (gp_elapsed_r == lpbc_pkg::PULSE_CNT_MAX) ? gp_elapsed_r
                                                             : gp_elapsed_r + 16'd1;
  assign rp_inc    = (rp_elapsed_r == lpbc_pkg::PULSE_CNT_MAX) ? rp_elapsed_r
                                                             : rp_elapsed_r + 16'd1;
  assign blink_inc = (blink_elapsed_r == lpbc_pkg::BLINK_CNT_MAX) ? blink_elapsed_r
                                                                : blink_elapsed_r + 15'd1;
  assign half_full = 15'(upd_word.value / lpbc_pkg::HALF_DIV);

  always_comb begin
    green_lit_nxt     = green_lit_r;
    red_lit_nxt       = red_lit_r;
    gp_run_nxt        = gp_run_r;
    gp_elapsed_nxt    = gp_elapsed_r;
    gp_length_nxt     = gp_length_r;
    rp_run_nxt        = rp_run_r;
    rp_elapsed_nxt    = rp_elapsed_r;
    rp_length_nxt     = rp_length_r;
    blink_run_nxt     = blink_run_r;
    blink_half_nxt    = blink_half_r;
    blink_elapsed_nxt = blink_elapsed_r;

    case (upd_word.action)
      lpbc_pkg::ACT_TICK: begin
        if (gp_run_r) begin
          gp_elapsed_nxt = gp_inc;
          if (gp_inc >= gp_length_r) begin
            green_lit_nxt = 1'b0;
            gp_run_nxt    = 1'b0;
          end
        end
        // a running red pulse owns red: hold the blink
        if (rp_run_r) begin
          rp_elapsed_nxt = rp_inc;
          if (rp_inc >= rp_length_r) begin
            red_lit_nxt = 1'b0;
            rp_run_nxt  = 1'b0;
          end
        end else if (blink_run_r) begin
          blink_elapsed_nxt = blink_inc;
          if (blink_inc >= blink_half_r) begin
            blink_elapsed_nxt = '0;
            red_lit_nxt       = ~red_lit_r;
          end
        end
      end
      lpbc_pkg::ACT_GREEN_SET: begin
        gp_run_nxt    = 1'b0;
        green_lit_nxt = upd_word.value[0];
      end
      lpbc_pkg::ACT_RED_SET: begin
        blink_run_nxt = 1'b0;
        rp_run_nxt    = 1'b0;
        red_lit_nxt   = upd_word.value[0];
      end
      lpbc_pkg::ACT_RED_BLINK: begin
        if (upd_word.value == 16'd0) begin
          blink_run_nxt = 1'b0;
          red_lit_nxt   = 1'b0;
        end else begin
          rp_run_nxt        = 1'b0;
          blink_run_nxt     = 1'b1;
          blink_half_nxt    = half_full;
          blink_elapsed_nxt = '0;
          red_lit_nxt       = 1'b1;
        end
      end
      lpbc_pkg::ACT_GREEN_PULSE: begin
        green_lit_nxt  = 1'b1;
        gp_run_nxt     = 1'b1;
        gp_elapsed_nxt = '0;
        gp_length_nxt  = upd_word.value;
      end
      lpbc_pkg::ACT_RED_PULSE: begin
        blink_run_nxt  = 1'b0;
        red_lit_nxt    = 1'b1;
        rp_run_nxt     = 1'b1;
        rp_elapsed_nxt = '0;
        rp_length_nxt  = upd_word.value;
      end
      default: begin
        // unused codes: drop, state unchanged
      end
    endcase
  end

  assign led_nxt.green_on = green_lit_nxt;
  assign led_nxt.red_on   = red_lit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      green_lit_r     <= 1'b0;
      red_lit_r       <= 1'b0;
      gp_run_r        <= 1'b0;
      gp_elapsed_r    <= '0;
      gp_length_r     <= '0;
      rp_run_r        <= 1'b0;
      rp_elapsed_r    <= '0;
      rp_length_r     <= '0;
      blink_run_r     <= 1'b0;
      blink_half_r    <= '0;
      blink_elapsed_r <= '0;
    end else if (upd_en) begin
      green_lit_r     <= green_lit_nxt;
      red_lit_r       <= red_lit_nxt;
      gp_run_r        <= gp_run_nxt;
      gp_elapsed_r    <= gp_elapsed_nxt;
      gp_length_r     <= gp_length_nxt;
      rp_run_r        <= rp_run_nxt;
      rp_elapsed_r    <= rp_elapsed_nxt;
      rp_length_r     <= rp_length_nxt;
      blink_run_r     <= blink_run_nxt;
      blink_half_r    <= blink_half_nxt;
      blink_elapsed_r <= blink_elapsed_nxt;
    end
  end

  // red pulse and blink never run together
  a_red_owner: assert property (@(posedge clk) disable iff (!rst_n)
    !(rp_run_r && blink_run_r))
    else $error("red pulse and blink both running");

  // blink count never passes its half period
  a_blink_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    blink_elapsed_r <= blink_half_r)
    else $error("blink count beyond half period");

  // a running green pulse keeps green lit
  a_green_pulse_lit: assert property (@(posedge clk) disable iff (!rst_n)
    gp_run_r |-> green_lit_r)
    else $error("green pulse running with green dark");

  // state holds when no word is applied
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !upd_en |=> $stable(green_lit_r) && $stable(red_lit_r) && $stable(blink_run_r))
    else $error("state changed without an update");

endmodule

@@ hdl/led_pulse_blink_controller_core.sv @@
// Top level: input register, LED state update and result register.
`timescale 1ns / 1ps
// Status LED controller. Each input word is a 1 ms tick or a command (green/red
// set, red blink, green/red pulse); every word yields one result word with both
// LED drives after that word. One word is accepted per cycle while in_stall is
// low; an accepted word goes into the input register, which feeds the update
// logic, which writes the result register once that register is free. A stalled result
// holds the result register, and the input side keeps taking words until the
// input register also fills.
module led_pulse_blink_controller_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lpbc_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lpbc_pkg::out_word_t out_data
);

  logic                s1_valid_r, s1_valid_nxt;
  lpbc_pkg::in_word_t  s1_word_r;
  logic                out_valid_r, out_valid_nxt;
  lpbc_pkg::out_word_t out_word_r;
  lpbc_pkg::out_word_t led_nxt;

  logic out_free;
  logic s1_go;
  logic in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !s1_go);
  assign out_valid_nxt = s1_go || (out_valid_r && out_stall);

  lpbc_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd_en   (s1_go),
    .upd_word (s1_word_r),
    .led_nxt  (led_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word_r <= in_data;
    end
    if (s1_go) begin
      out_word_r <= led_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // a held word in the input register must stall the input side
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |-> in_stall)
    else $error("input taken over a held word");

  // the input register advances only into a free result register
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> out_valid_r)
    else $error("word lost on advance");

  // a stalled result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r)
    else $error("stalled result dropped");

endmodule
